// ----- rtl/amu_pkg.sv -----
package amu_pkg;

   localparam int ELEMENTS_DEFAULT = 1024;
   localparam int JOB_IDX_W = 16;
   localparam int DIV_STEPS = 49;
   localparam int SQRT_STEPS = 25;

   localparam logic [16:0] Q_ONE = 17'd65536;
   localparam logic [16:0] Q_HALF = 17'd32768;
   localparam logic [48:0] ROOT_NUM = 49'h1_0000_0000_0000;

   localparam logic [15:0] BETA_ONE_RESET = 16'd58982;
   localparam logic [15:0] BETA_TWO_RESET = 16'd65470;
   localparam logic [15:0] EPSILON_RESET = 16'd1;

   typedef enum logic [1:0] {
      REG_BETA_ONE = 2'd0,
      REG_BETA_TWO = 2'd1,
      REG_EPSILON  = 2'd2
   } amu_reg_type;

   typedef enum logic [1:0] {
      JOB_M,
      JOB_S,
      JOB_R
   } amu_div_job_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_MUL4,
      ST_MUL5,
      ST_MUL6,
      ST_MUL7,
      ST_MUL8,
      ST_CORR_M,
      ST_CORR_S,
      ST_ROOT,
      ST_DIV,
      ST_SQRT,
      ST_OUT
   } amu_state_type;

   typedef struct packed {
      logic [9:0]         element_index;
      logic signed [31:0] gradient;
      logic               new_step;
   } amu_req_type;

   typedef struct packed {
      logic signed [31:0] m_corrected;
      logic [31:0]        s_corrected;
      logic [31:0]        inv_root;
      logic               saturated;
   } amu_rsp_type;

   typedef struct packed {
      logic [JOB_IDX_W-1:0] idx;
      logic signed [31:0]   gradient;
      logic [16:0]          d_one;
      logic [16:0]          d_two;
   } amu_job_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } amu_ctl_type;

endpackage

// ----- rtl/adam_moment_update.sv -----
// Adam moment update in Q16.16. Each item updates the first and second moment of one
// element and returns the bias-corrected moments and 1/sqrt(s_corrected+epsilon). After
// reset both moment memories are swept to zero, one element per cycle, over all ELEMENTS
// entries (1024 by default); req_full stays high during that sweep. The front takes items
// into a two-entry queue and advances the beta powers; the back end works on one item at
// a time: one pop, one memory read, eight steps of a shared 33x33 multiplier, three
// bit-serial divisions (two bias corrections and 2^48/x) and a bit-serial square root. A
// zero moment or a step not yet started skips its division. A finished result waits in
// an output register while the next item is started.
module adam_moment_update #(
   parameter int ELEMENTS = amu_pkg::ELEMENTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  amu_pkg::amu_req_type req_item,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output amu_pkg::amu_rsp_type rsp_item,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import amu_pkg::*;

   logic [15:0] beta_one_ff, beta_two_ff, epsilon_ff;
   logic csr_write;
   amu_ctl_type ctl;
   amu_job_type job;
   logic job_valid;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_one_ff <= BETA_ONE_RESET;
         beta_two_ff <= BETA_TWO_RESET;
         epsilon_ff <= EPSILON_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_BETA_ONE: beta_one_ff <= csr_pwdata[15:0];
            REG_BETA_TWO: beta_two_ff <= csr_pwdata[15:0];
            REG_EPSILON:  epsilon_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_BETA_ONE: csr_prdata = {16'd0, beta_one_ff};
         REG_BETA_TWO: csr_prdata = {16'd0, beta_two_ff};
         REG_EPSILON:  csr_prdata = {16'd0, epsilon_ff};
         default:      csr_prdata = '0;
      endcase
   end

   amu_front #(.ELEMENTS(ELEMENTS)) u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_item(req_item),
      .beta_one(beta_one_ff), .beta_two(beta_two_ff),
      .ctl(ctl), .job_valid(job_valid), .job(job)
   );

   amu_back #(.ELEMENTS(ELEMENTS)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job(job), .ctl(ctl),
      .beta_one(beta_one_ff), .beta_two(beta_two_ff), .epsilon_value(epsilon_ff),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_item(rsp_item)
   );

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      ctl.clearing |-> req_full)
      else $error("item accepted during memory sweep");

   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> job_valid)
      else $error("back end popped an empty queue");

   a_root_max_saturates: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.inv_root == 32'hFFFF_FFFF) |-> rsp_item.saturated)
      else $error("zero root argument without saturation flag");
endmodule

// ----- rtl/amu_ram.sv -----
module amu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/amu_front.sv -----
module amu_front #(
   parameter int ELEMENTS = amu_pkg::ELEMENTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  amu_pkg::amu_req_type req_item,
   input  logic [15:0]          beta_one,
   input  logic [15:0]          beta_two,
   input  amu_pkg::amu_ctl_type ctl,
   output logic                 job_valid,
   output amu_pkg::amu_job_type job
);
   import amu_pkg::*;

   localparam int IDX_W = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

   logic [16:0] pow_one_ff, pow_one_in, pow_two_ff, pow_two_in;
   logic [33:0] prod_one, prod_two;
   logic [IDX_W-1:0] idx_wrap;
   amu_job_type ent_ff [2];
   amu_job_type new_job;
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic accept;

   // power advance for a new step
   assign prod_one = 34'(pow_one_ff) * 34'(beta_one) + 34'(Q_HALF);
   assign prod_two = 34'(pow_two_ff) * 34'(beta_two) + 34'(Q_HALF);
   assign pow_one_in = req_item.new_step ? 17'(prod_one >> 16) : pow_one_ff;
   assign pow_two_in = req_item.new_step ? 17'(prod_two >> 16) : pow_two_ff;

   assign idx_wrap = IDX_W'(32'(req_item.element_index) % ELEMENTS);

   always_comb begin
      new_job.idx = JOB_IDX_W'(idx_wrap);
      new_job.gradient = req_item.gradient;
      new_job.d_one = 17'(Q_ONE - pow_one_in);
      new_job.d_two = 17'(Q_ONE - pow_two_in);
   end

   assign req_full = (cnt_ff == 2'd2) || ctl.clearing;
   assign accept = req_push && !req_full;
   assign cnt_in = 2'(cnt_ff + {1'b0, accept} - {1'b0, ctl.pop});
   assign job_valid = (cnt_ff != 2'd0);
   assign job = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         pow_one_ff <= Q_ONE;
         pow_two_ff <= Q_ONE;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (accept) begin
            pow_one_ff <= pow_one_in;
            pow_two_ff <= pow_two_in;
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (ctl.pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ent_ff[wr_ptr_ff] <= new_job;
      end
   end
endmodule

// ----- rtl/amu_back.sv -----
module amu_back #(
   parameter int ELEMENTS = amu_pkg::ELEMENTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  amu_pkg::amu_job_type job,
   output amu_pkg::amu_ctl_type ctl,
   input  logic [15:0]          beta_one,
   input  logic [15:0]          beta_two,
   input  logic [15:0]          epsilon_value,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output amu_pkg::amu_rsp_type rsp_item
);
   import amu_pkg::*;

   localparam int IDX_W = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

   amu_state_type state_ff, state_in;
   amu_job_type job_ff, job_in;
   amu_div_job_type sel_ff, sel_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic signed [65:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [32:0] mul_a, mul_b;
   logic [31:0] m_new_ff, m_new_in, su_ff, su_in;
   logic [31:0] mc_ff, mc_in, sc_ff, sc_in, invr_ff, invr_in;
   logic [46:0] sq_ff, sq_in;
   logic sat_ff, sat_in;
   logic [32:0] rem_ff, rem_in, divisor_ff, divisor_in;
   logic [48:0] quo_ff, quo_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [49:0] rad_ff, rad_in;
   logic [24:0] root_ff, root_in;
   logic [27:0] srem_ff, srem_in;
   logic out_valid_ff, out_valid_in;
   amu_rsp_type out_ff, out_in;

   logic [31:0] m_old, s_old;
   logic m_we, s_we;
   logic [IDX_W-1:0] waddr;
   logic [31:0] m_wdata, s_wdata;

   logic [31:0] ag;
   logic signed [49:0] m_full;
   logic m_ovf;
   logic [31:0] m_sat, su_val;
   logic [65:0] sq_sum;
   logic [32:0] mag_m, root_x;
   logic [33:0] rem_sh;
   logic qbit;
   logic [48:0] quo_next;
   logic [29:0] srem_sh, trial;
   logic root_ge;
   logic [24:0] root_next;

   amu_ram #(.WIDTH(32), .DEPTH(ELEMENTS)) u_first (
      .clock(clock), .we(m_we), .waddr(waddr), .wdata(m_wdata),
      .raddr(job_ff.idx[IDX_W-1:0]), .rdata(m_old)
   );

   amu_ram #(.WIDTH(32), .DEPTH(ELEMENTS)) u_second (
      .clock(clock), .we(s_we), .waddr(waddr), .wdata(s_wdata),
      .raddr(job_ff.idx[IDX_W-1:0]), .rdata(s_old)
   );

   assign ag = job_ff.gradient[31] ? 32'(~job_ff.gradient + 32'd1) : job_ff.gradient;
   assign m_full = acc_ff[65:16];
   assign m_ovf = !((&m_full[49:31]) || !(|m_full[49:31]));
   assign m_sat = m_ovf ? (m_full[49] ? 32'h8000_0000 : 32'h7FFF_FFFF) : m_full[31:0];
   assign su_val = (|acc_ff[65:48]) ? 32'hFFFF_FFFF : acc_ff[47:16];
   assign sq_sum = prod_ff + 66'(Q_HALF);
   assign mag_m = m_new_ff[31] ? (33'd0 - {1'b1, m_new_ff}) : {1'b0, m_new_ff};
   assign root_x = 33'(sc_ff) + 33'(epsilon_value);
   assign rem_sh = {rem_ff, quo_ff[48]};
   assign qbit = (rem_sh >= {1'b0, divisor_ff});
   assign quo_next = {quo_ff[47:0], qbit};
   assign srem_sh = {srem_ff, rad_ff[49:48]};
   assign trial = 30'({root_ff, 2'b01});
   assign root_ge = (srem_sh >= trial);
   assign root_next = {root_ff[23:0], root_ge};
   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      sel_in = sel_ff;
      clr_in = clr_ff;
      acc_in = acc_ff;
      m_new_in = m_new_ff;
      su_in = su_ff;
      mc_in = mc_ff;
      sc_in = sc_ff;
      invr_in = invr_ff;
      sq_in = sq_ff;
      sat_in = sat_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      rad_in = rad_ff;
      root_in = root_ff;
      srem_in = srem_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in = out_ff;
      mul_a = '0;
      mul_b = '0;
      m_we = 1'b0;
      s_we = 1'b0;
      waddr = job_ff.idx[IDX_W-1:0];
      m_wdata = m_sat;
      s_wdata = su_val;
      ctl.pop = 1'b0;
      ctl.clearing = (state_ff == ST_CLEAR);

      case (state_ff)
         ST_CLEAR: begin
            m_we = 1'b1;
            s_we = 1'b1;
            waddr = clr_ff;
            m_wdata = '0;
            s_wdata = '0;
            clr_in = IDX_W'(clr_ff + 1'b1);
            if (clr_ff == IDX_W'(ELEMENTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (job_valid) begin
               ctl.pop = 1'b1;
               job_in = job;
               sat_in = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            mul_a = 33'(beta_one);
            mul_b = {m_old[31], m_old};
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            acc_in = prod_ff;
            mul_a = 33'(17'(Q_ONE - {1'b0, beta_one}));
            mul_b = {job_ff.gradient[31], job_ff.gradient};
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            acc_in = acc_ff - prod_ff + 66'(Q_HALF);
            mul_a = {1'b0, ag};
            mul_b = {1'b0, ag};
            state_in = ST_MUL4;
         end
         ST_MUL4: begin
            m_new_in = m_sat;
            m_we = 1'b1;
            if (m_ovf) begin
               sat_in = 1'b1;
            end
            sq_in = sq_sum[62:16];
            mul_a = 33'(beta_two);
            mul_b = {1'b0, s_old};
            state_in = ST_MUL5;
         end
         ST_MUL5: begin
            acc_in = prod_ff + 66'(Q_HALF);
            mul_a = 33'(17'(Q_ONE - {1'b0, beta_two}));
            mul_b = 33'(sq_ff[46:23]);
            state_in = ST_MUL6;
         end
         ST_MUL6: begin
            acc_in = acc_ff + (prod_ff <<< 23);
            mul_a = 33'(17'(Q_ONE - {1'b0, beta_two}));
            mul_b = 33'(sq_ff[22:0]);
            state_in = ST_MUL7;
         end
         ST_MUL7: begin
            acc_in = acc_ff + prod_ff;
            state_in = ST_MUL8;
         end
         ST_MUL8: begin
            su_in = su_val;
            s_we = 1'b1;
            if (|acc_ff[65:48]) begin
               sat_in = 1'b1;
            end
            state_in = ST_CORR_M;
         end
         ST_CORR_M: begin
            if (mag_m == '0) begin
               mc_in = '0;
               state_in = ST_CORR_S;
            end else if (job_ff.d_one == '0) begin
               sat_in = 1'b1;
               mc_in = m_new_ff[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               state_in = ST_CORR_S;
            end else begin
               rem_in = '0;
               quo_in = {mag_m, 16'd0} + 49'(job_ff.d_one >> 1);
               divisor_in = 33'(job_ff.d_one);
               cnt_in = '0;
               sel_in = JOB_M;
               state_in = ST_DIV;
            end
         end
         ST_CORR_S: begin
            if (su_ff == '0) begin
               sc_in = '0;
               state_in = ST_ROOT;
            end else if (job_ff.d_two == '0) begin
               sat_in = 1'b1;
               sc_in = 32'hFFFF_FFFF;
               state_in = ST_ROOT;
            end else begin
               rem_in = '0;
               quo_in = {1'b0, su_ff, 16'd0} + 49'(job_ff.d_two >> 1);
               divisor_in = 33'(job_ff.d_two);
               cnt_in = '0;
               sel_in = JOB_S;
               state_in = ST_DIV;
            end
         end
         ST_ROOT: begin
            if (root_x == '0) begin
               sat_in = 1'b1;
               invr_in = 32'hFFFF_FFFF;
               state_in = ST_OUT;
            end else begin
               rem_in = '0;
               quo_in = ROOT_NUM;
               divisor_in = root_x;
               cnt_in = '0;
               sel_in = JOB_R;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = qbit ? 33'(rem_sh - {1'b0, divisor_ff}) : rem_sh[32:0];
            quo_in = quo_next;
            cnt_in = 6'(cnt_ff + 1'b1);
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               case (sel_ff)
                  JOB_M: begin
                     if (m_new_ff[31]) begin
                        if (quo_next > 49'h0_8000_0000) begin
                           sat_in = 1'b1;
                           mc_in = 32'h8000_0000;
                        end else begin
                           mc_in = 32'd0 - quo_next[31:0];
                        end
                     end else begin
                        if (quo_next > 49'h0_7FFF_FFFF) begin
                           sat_in = 1'b1;
                           mc_in = 32'h7FFF_FFFF;
                        end else begin
                           mc_in = quo_next[31:0];
                        end
                     end
                     state_in = ST_CORR_S;
                  end
                  JOB_S: begin
                     if (|quo_next[48:32]) begin
                        sat_in = 1'b1;
                        sc_in = 32'hFFFF_FFFF;
                     end else begin
                        sc_in = quo_next[31:0];
                     end
                     state_in = ST_ROOT;
                  end
                  JOB_R: begin
                     rad_in = {1'b0, quo_next};
                     root_in = '0;
                     srem_in = '0;
                     cnt_in = '0;
                     state_in = ST_SQRT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SQRT: begin
            srem_in = root_ge ? 28'(srem_sh - trial) : 28'(srem_sh);
            root_in = root_next;
            rad_in = {rad_ff[47:0], 2'b00};
            cnt_in = 6'(cnt_ff + 1'b1);
            if (cnt_ff == 6'(SQRT_STEPS - 1)) begin
               invr_in = 32'(root_next);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_in.m_corrected = mc_ff;
               out_in.s_corrected = sc_ff;
               out_in.inv_root = invr_ff;
               out_in.saturated = sat_ff;
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      sel_ff <= sel_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      m_new_ff <= m_new_in;
      su_ff <= su_in;
      mc_ff <= mc_in;
      sc_ff <= sc_in;
      invr_ff <= invr_in;
      sq_ff <= sq_in;
      sat_ff <= sat_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      rad_ff <= rad_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item = out_ff;
endmodule

// ----- sim/testbench.sv -----
module testbench;
   import amu_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   amu_req_type req_item = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   amu_rsp_type rsp_item;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   adam_moment_update uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] m_mem [1024];
   logic [31:0] s_mem [1024];
   logic [16:0] pow_one, pow_two;
   logic [15:0] b_one, b_two, eps;

   amu_rsp_type expected_q[$];
   int errors = 0;
   int long_hold = 0;

   function automatic longint round_div(longint w);
      if (w >= 0) return w >>> 16;
      return -((-w + 65535) >>> 16);
   endfunction

   function automatic longint bias_fix(longint unsigned mag, bit neg, logic [16:0] pw,
                                       longint lo, longint hi, ref bit sat);
      longint unsigned d, q;
      d = (pw >= 17'd65536) ? 0 : 65536 - pw;
      if (mag == 0) return 0;
      if (d == 0) begin
         sat = 1;
         return neg ? lo : hi;
      end
      q = ((mag << 16) + d / 2) / d;
      if (neg) begin
         if (q > longint'(-lo)) begin
            sat = 1;
            return lo;
         end
         return -longint'(q);
      end
      if (q > hi) begin
         sat = 1;
         return hi;
      end
      return q;
   endfunction

   function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic amu_rsp_type moment_predict(amu_req_type it);
      amu_rsp_type r;
      bit sat;
      longint g, t, m, mc;
      longint unsigned ag, sq, su, sc, x, inv;
      int idx;
      sat = 0;
      idx = it.element_index;
      g = longint'(it.gradient);
      if (it.new_step) begin
         pow_one = 17'((64'(pow_one) * b_one + 32768) >> 16);
         pow_two = 17'((64'(pow_two) * b_two + 32768) >> 16);
      end
      t = longint'(b_one) * longint'(m_mem[idx]) - longint'(65536 - b_one) * g;
      m = round_div(t + 32768);
      if (m > 64'sd2147483647) begin
         m = 64'sd2147483647;
         sat = 1;
      end
      if (m < -64'sd2147483648) begin
         m = -64'sd2147483648;
         sat = 1;
      end
      m_mem[idx] = 32'(m);
      ag = (g < 0) ? -g : g;
      sq = (ag * ag + 32768) >> 16;
      su = (64'(b_two) * s_mem[idx] + 64'(65536 - b_two) * sq + 32768) >> 16;
      if (su > 64'hFFFFFFFF) begin
         su = 64'hFFFFFFFF;
         sat = 1;
      end
      s_mem[idx] = 32'(su);
      mc = bias_fix((m < 0) ? -m : m, m < 0, pow_one, -64'sd2147483648,
                    64'sd2147483647, sat);
      sc = bias_fix(su, 0, pow_two, 0, 64'hFFFFFFFF, sat);
      x = sc + eps;
      if (x == 0) begin
         inv = 64'hFFFFFFFF;
         sat = 1;
      end else begin
         inv = int_root((64'd1 << 48) / x);
      end
      r.m_corrected = 32'(mc);
      r.s_corrected = 32'(sc);
      r.inv_root = 32'(inv);
      r.saturated = sat;
      return r;
   endfunction

   task automatic send_item(logic [9:0] idx, logic [31:0] g, logic ns, bit gaps = 1);
      amu_req_type it;
      int gap;
      gap = 0;
      if (gaps) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      end
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      it.element_index = idx;
      it.gradient = g;
      it.new_step = ns;
      req_item <= it;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_q.push_back(moment_predict(it));
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic csr_write(amu_reg_type r, logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 4'(r) << 2;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (r)
         REG_BETA_ONE: b_one = v[15:0];
         REG_BETA_TWO: b_two = v[15:0];
         default: eps = v[15:0];
      endcase
   endtask

   function automatic logic [31:0] rand_grad();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 400000)) - 200000);
         2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         default: return 32'(-($urandom_range(0, 65536 * 8)));
      endcase
   endfunction

   task automatic test_directed();
      // items before and after the first step starts: zero and nonzero moments
      send_item(0, 0, 0);
      send_item(1, 32'h0001_0000, 0);
      send_item(1023, 32'h7FFF_FFFF, 1);
      send_item(1023, 32'h8000_0000, 0);
      send_item(2, 32'h8000_0000, 0);
      send_item(3, 32'hFFFF_FFFF, 1);
      send_item(4, 0, 0);
      send_item(5, 32'h7FFF_FFFF, 0);
      send_item(5, 32'h7FFF_FFFF, 0);
      send_item(10'h2AA, 32'hAAAA_AAAA, 1);
      send_item(10'h155, 32'h5555_5555, 0);
      drain();
   endtask

   task automatic test_config_extremes();
      // zero epsilon with zero moment gives a zero root argument
      csr_write(REG_EPSILON, 32'hFFFF_0000);
      csr_write(REG_BETA_ONE, 0);
      csr_write(REG_BETA_TWO, 0);
      send_item(6, 0, 1);
      send_item(7, 32'h0000_0100, 0);
      send_item(7, 32'h8000_0000, 1);
      drain();
      csr_write(REG_BETA_ONE, 16'hFFFF);
      csr_write(REG_BETA_TWO, 16'hFFFF);
      csr_write(REG_EPSILON, 16'hFFFF);
      send_item(8, 32'h7FFF_FFFF, 1);
      send_item(8, 32'h7FFF_FFFF, 0);
      send_item(9, 32'h0000_0001, 1);
      drain();
   endtask

   task automatic run_steps(int n, int elems);
      int base;
      base = $urandom_range(0, 1023);
      for (int i = 0; i < n; i++)
         send_item(10'((base + (i % elems)) % 1024), rand_grad(), (i % elems) == 0);
   endtask

   task automatic test_random();
      logic [15:0] settings [4][3];
      settings[0] = '{16'd58982, 16'd65470, 16'd1};
      settings[1] = '{16'd32768, 16'd60000, 16'd100};
      settings[2] = '{16'($urandom), 16'($urandom), 16'($urandom)};
      settings[3] = '{16'd65000, 16'd65535, 16'd0};
      for (int p = 0; p < 4; p++) begin
         csr_write(REG_BETA_ONE, {16'($urandom), settings[p][0]});
         csr_write(REG_BETA_TWO, settings[p][1]);
         csr_write(REG_EPSILON, settings[p][2]);
         for (int k = 0; k < 30; k++)
            run_steps($urandom_range(4, 12), $urandom_range(1, 8));
         // noise on any index
         for (int k = 0; k < 20; k++)
            send_item(10'($urandom), rand_grad(), $urandom_range(0, 4) == 0);
         drain();
      end
   endtask

   task automatic test_backpressure();
      long_hold = 800;
      for (int i = 0; i < 12; i++)
         send_item(10'(i), rand_grad(), i == 0, 0);
      drain();
   endtask

   always @(posedge clock) begin
      if (long_hold != 0) long_hold <= long_hold - 1;
   end

   // result side: random pop with gaps, checked at the accepting edge
   initial begin
      amu_rsp_type e;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            if (expected_q.size() == 0) begin
               $display("%0t unexpected result %h", $realtime, rsp_item);
               errors++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_item.m_corrected !== e.m_corrected)
                  $display("%0t m_corrected exp %h got %h", $realtime, e.m_corrected,
                           rsp_item.m_corrected);
               if (rsp_item.s_corrected !== e.s_corrected)
                  $display("%0t s_corrected exp %h got %h", $realtime, e.s_corrected,
                           rsp_item.s_corrected);
               if (rsp_item.inv_root !== e.inv_root)
                  $display("%0t inv_root exp %h got %h", $realtime, e.inv_root,
                           rsp_item.inv_root);
               if (rsp_item.saturated !== e.saturated)
                  $display("%0t saturated exp %b got %b", $realtime, e.saturated,
                           rsp_item.saturated);
               if (rsp_item !== e) errors++;
            end
         end
         if (long_hold != 0) rsp_pop <= 1'b0;
         else if ($urandom_range(0, 19) == 0) rsp_pop <= 1'b0;
         else rsp_pop <= ($urandom_range(0, 3) != 0);
      end
   end

   initial begin
      for (int i = 0; i < 1024; i++) begin
         m_mem[i] = '0;
         s_mem[i] = '0;
      end
      pow_one = 17'd65536;
      pow_two = 17'd65536;
      b_one = BETA_ONE_RESET;
      b_two = BETA_TWO_RESET;
      eps = EPSILON_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_backpressure();
      test_random();
      drain();
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #20000000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
